### rtl/cbpe_pkg.sv
// Shared constants and types for the cubic Bezier point evaluator.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package cbpe_pkg;

   // Default widths of a pixel coordinate and of the fraction of t.
   localparam int COORD_BITS_DEF  = 12;
   localparam int T_FRAC_BITS_DEF = 16;

   // Number of control points of a cubic curve.
   localparam int NUM_CTRL = 4;

   // Width of the register index on the configuration port.
   localparam int CSR_INDEX_BITS = 3;

   // Register map of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CTRL0_X = 3'd0,
      CSR_CTRL0_Y = 3'd1,
      CSR_CTRL1_X = 3'd2,
      CSR_CTRL1_Y = 3'd3,
      CSR_CTRL2_X = 3'd4,
      CSR_CTRL2_Y = 3'd5,
      CSR_CTRL3_X = 3'd6,
      CSR_CTRL3_Y = 3'd7
   } csr_index_type;

endpackage

`default_nettype wire

### rtl/cbpe_if.sv
// Request and response channel interfaces of the cubic Bezier evaluator.
// Depends on cbpe_pkg for the default widths.
`default_nettype none

interface cbpe_req_if #(
   parameter int T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   logic [T_FRAC_BITS:0] param_t;

   modport source (output valid, output param_t, input ready);
   modport sink   (input valid, input param_t, output ready);
endinterface

interface cbpe_rsp_if #(
   parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

### rtl/cbpe_weight.sv
// Three-stage pipeline that turns t into the four Bernstein weights.
// Depends on cbpe_pkg for NUM_CTRL.
`default_nettype none

module cbpe_weight #(
   parameter int T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [T_FRAC_BITS:0]     in_t,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [3*T_FRAC_BITS:0]   out_weight [cbpe_pkg::NUM_CTRL]
);
   import cbpe_pkg::*;

   localparam int F  = T_FRAC_BITS;
   localparam int P2 = 2*F + 1;   // squares and cross term, up to 2^(2F)
   localparam int W  = 3*F + 1;   // weights, up to 2^(3F)
   localparam logic [F:0] ONE = (F+1)'(1) << F;

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic          adv1, adv2, adv3;
   logic [F:0]    s1_t_ff, s1_u_ff, s2_t_ff, s2_u_ff;
   logic [F:0]    t_clamp;
   logic [P2-1:0] s2_tt_ff, s2_uu_ff, s2_tu_ff;
   logic [2*F+1:0] tt_full, uu_full, tu_full;
   logic [3*F+2:0] w0_full, w3_full, m1_full, m2_full;
   logic [W-1:0]  m1, m2;
   logic [W-1:0]  s3_w_ff [NUM_CTRL];

   // A stage moves when it is empty or the stage after it moves.
   assign adv3     = !s3_valid_ff || out_ready;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   // Any t with the integer bit set is at least one, so it clamps to one.
   assign t_clamp = in_t[F] ? ONE : in_t;

   // Products of the second and third stages at full width.
   always_comb begin
      tt_full = s1_t_ff * s1_t_ff;
      uu_full = s1_u_ff * s1_u_ff;
      tu_full = s1_t_ff * s1_u_ff;
      w0_full = s2_uu_ff * s2_u_ff;
      w3_full = s2_tt_ff * s2_t_ff;
      m1_full = s2_tu_ff * s2_u_ff;
      m2_full = s2_tu_ff * s2_t_ff;
      m1      = m1_full[W-1:0];
      m2      = m2_full[W-1:0];
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= in_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: clamped t and u = 1 - t.
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_t_ff <= t_clamp;
         s1_u_ff <= ONE - t_clamp;
      end
   end

   // Stage 2: t^2, u^2 and t*u.
   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_t_ff  <= s1_t_ff;
         s2_u_ff  <= s1_u_ff;
         s2_tt_ff <= tt_full[P2-1:0];
         s2_uu_ff <= uu_full[P2-1:0];
         s2_tu_ff <= tu_full[P2-1:0];
      end
   end

   // Stage 3: u^3, 3*t*u^2, 3*t^2*u and t^3; the factor three is a shift and add.
   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_w_ff[0] <= w0_full[W-1:0];
         s3_w_ff[1] <= m1 + {m1[W-2:0], 1'b0};
         s3_w_ff[2] <= m2 + {m2[W-2:0], 1'b0};
         s3_w_ff[3] <= w3_full[W-1:0];
      end
   end

   assign out_valid  = s3_valid_ff;
   assign out_weight = s3_w_ff;

endmodule

`default_nettype wire

### rtl/cbpe_blend.sv
// Two-stage pipeline that weights the control points and sums them per axis.
// Depends on cbpe_pkg for NUM_CTRL.
`default_nettype none

module cbpe_blend #(
   parameter int COORD_BITS  = cbpe_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [3*T_FRAC_BITS:0] in_weight [cbpe_pkg::NUM_CTRL],
   input  logic [COORD_BITS-1:0]  ctrl_x    [cbpe_pkg::NUM_CTRL],
   input  logic [COORD_BITS-1:0]  ctrl_y    [cbpe_pkg::NUM_CTRL],
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [COORD_BITS-1:0]  point_x,
   output logic [COORD_BITS-1:0]  point_y
);
   import cbpe_pkg::*;

   localparam int C = COORD_BITS;
   localparam int W = 3*T_FRAC_BITS + 1;
   localparam int S = W + C - 1;   // a weighted coordinate stays below 2^(3F+C)

   logic         s4_valid_ff, s5_valid_ff;
   logic         adv4, adv5;
   logic [W+C-1:0] prod_x_full [NUM_CTRL];
   logic [W+C-1:0] prod_y_full [NUM_CTRL];
   logic [S-1:0] s4_px_ff [NUM_CTRL];
   logic [S-1:0] s4_py_ff [NUM_CTRL];
   logic [S-1:0] sum_x, sum_y;
   logic [C-1:0] s5_x_ff, s5_y_ff;

   assign adv5     = !s5_valid_ff || out_ready;
   assign adv4     = !s4_valid_ff || adv5;
   assign in_ready = adv4;

   // One multiplier per control point and axis.
   always_comb begin
      for (int i = 0; i < NUM_CTRL; i++) begin
         prod_x_full[i] = in_weight[i] * ctrl_x[i];
         prod_y_full[i] = in_weight[i] * ctrl_y[i];
      end
   end

   // The weights sum to exactly one, so the total cannot overflow.
   assign sum_x = (s4_px_ff[0] + s4_px_ff[1]) + (s4_px_ff[2] + s4_px_ff[3]);
   assign sum_y = (s4_py_ff[0] + s4_py_ff[1]) + (s4_py_ff[2] + s4_py_ff[3]);

   // Valid bits of the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (adv4) s4_valid_ff <= in_valid;
         if (adv5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 4: weighted coordinates.
   always_ff @(posedge clock) begin
      if (adv4) begin
         for (int i = 0; i < NUM_CTRL; i++) begin
            s4_px_ff[i] <= prod_x_full[i][S-1:0];
            s4_py_ff[i] <= prod_y_full[i][S-1:0];
         end
      end
   end

   // Stage 5: sum and truncate to a whole pixel by dropping 3F fraction bits.
   always_ff @(posedge clock) begin
      if (adv5) begin
         s5_x_ff <= sum_x[3*T_FRAC_BITS +: C];
         s5_y_ff <= sum_y[3*T_FRAC_BITS +: C];
      end
   end

   assign out_valid = s5_valid_ff;
   assign point_x   = s5_x_ff;
   assign point_y   = s5_y_ff;

endmodule

`default_nettype wire

### rtl/cubic_bezier_point_eval_core.sv
// Cubic Bezier point evaluator: control point registers, weight and blend pipelines.
// Throughput is one request per clock while the response side is ready; each of
// the five stages holds one item and the stall chain through the stages lets the
// pipeline fill completely.
// Reset clears all stage valid bits and sets every control coordinate to zero.
// Depends on cbpe_pkg, cbpe_if, cbpe_weight and cbpe_blend.
`default_nettype none

module cubic_bezier_point_eval_core #(
   parameter int COORD_BITS  = cbpe_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   cbpe_req_if.sink                req_bus,
   cbpe_rsp_if.source              rsp_bus,
   input  logic                    csr_wr_en,
   input  cbpe_pkg::csr_index_type csr_index,
   input  logic [COORD_BITS-1:0]   csr_wdata
);
   import cbpe_pkg::*;

   localparam int W = 3*T_FRAC_BITS + 1;

   logic [COORD_BITS-1:0] ctrl_x_ff [NUM_CTRL];
   logic [COORD_BITS-1:0] ctrl_y_ff [NUM_CTRL];
   logic [COORD_BITS-1:0] ctrl_x_in [NUM_CTRL];
   logic [COORD_BITS-1:0] ctrl_y_in [NUM_CTRL];
   logic                  wgt_valid, wgt_ready;
   logic [W-1:0]          wgt_weight [NUM_CTRL];

   // Register write decode.
   always_comb begin
      ctrl_x_in = ctrl_x_ff;
      ctrl_y_in = ctrl_y_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CTRL0_X: ctrl_x_in[0] = csr_wdata;
            CSR_CTRL0_Y: ctrl_y_in[0] = csr_wdata;
            CSR_CTRL1_X: ctrl_x_in[1] = csr_wdata;
            CSR_CTRL1_Y: ctrl_y_in[1] = csr_wdata;
            CSR_CTRL2_X: ctrl_x_in[2] = csr_wdata;
            CSR_CTRL2_Y: ctrl_y_in[2] = csr_wdata;
            CSR_CTRL3_X: ctrl_x_in[3] = csr_wdata;
            CSR_CTRL3_Y: ctrl_y_in[3] = csr_wdata;
         endcase
      end
   end

   // Control point registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CTRL; i++) begin
            ctrl_x_ff[i] <= '0;
            ctrl_y_ff[i] <= '0;
         end
      end else begin
         ctrl_x_ff <= ctrl_x_in;
         ctrl_y_ff <= ctrl_y_in;
      end
   end

   // Stages one to three: clamp t and form the basis weights.
   cbpe_weight #(
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_weight (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_t       (req_bus.param_t),
      .out_valid  (wgt_valid),
      .out_ready  (wgt_ready),
      .out_weight (wgt_weight)
   );

   // Stages four and five: weighted sums and truncation to pixels.
   cbpe_blend #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wgt_valid),
      .in_ready  (wgt_ready),
      .in_weight (wgt_weight),
      .ctrl_x    (ctrl_x_ff),
      .ctrl_y    (ctrl_y_ff),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .point_x   (rsp_bus.point_x),
      .point_y   (rsp_bus.point_y)
   );

endmodule

`default_nettype wire

### verif/tb_cubic_bezier_point_eval_core.sv
// Self-checking testbench for the cubic Bezier point evaluator core.
// Depends on cbpe_pkg, cbpe_if and the core; drives requests, programs control points
// and checks every response against a local fixed-point prediction of the curve.
`default_nettype none

module tb_cubic_bezier_point_eval_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cbpe_pkg::*;

   localparam int COORD  = COORD_BITS_DEF;
   localparam int T_FRAC = T_FRAC_BITS_DEF;
   localparam bit [63:0] T_ONE = 64'd1 << T_FRAC;
   localparam bit [COORD-1:0] COORD_MAX = {COORD{1'b1}};
   localparam int REQ_PER_PHASE = 155;
   localparam int NUM_PHASES = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      bit [COORD-1:0] x;
      bit [COORD-1:0] y;
   } curve_point_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [COORD-1:0] csr_wdata;

   cbpe_req_if #(.T_FRAC_BITS(T_FRAC)) req_bus ();
   cbpe_rsp_if #(.COORD_BITS(COORD)) rsp_bus ();

   cubic_bezier_point_eval_core #(
      .COORD_BITS(COORD),
      .T_FRAC_BITS(T_FRAC)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow of the control point registers, in register index order.
   bit [7:0][COORD-1:0] ctrl_shadow;
   curve_point_type expected_points[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit send_idle_on = 1'b0;
   bit recv_idle_on = 1'b0;
   int recv_stall_left = 0;

   always #5 clock = ~clock;

   // Exact Bernstein blend of one axis, truncated to a whole pixel.
   function automatic bit [COORD-1:0] blend_axis(input bit [T_FRAC:0] param,
                                                 input bit [COORD-1:0] p0,
                                                 input bit [COORD-1:0] p1,
                                                 input bit [COORD-1:0] p2,
                                                 input bit [COORD-1:0] p3);
      bit [63:0] t;
      bit [63:0] u;
      bit [63:0] sum;
      t = (param > T_ONE) ? T_ONE : {47'd0, param};
      u = T_ONE - t;
      sum = u * u * u * 64'(p0) + 64'd3 * t * u * u * 64'(p1) +
            64'd3 * t * t * u * 64'(p2) + t * t * t * 64'(p3);
      return sum[3*T_FRAC +: COORD];
   endfunction

   function automatic curve_point_type predict_point(input bit [T_FRAC:0] param);
      curve_point_type pt;
      pt.x = blend_axis(param, ctrl_shadow[0], ctrl_shadow[2], ctrl_shadow[4], ctrl_shadow[6]);
      pt.y = blend_axis(param, ctrl_shadow[1], ctrl_shadow[3], ctrl_shadow[5], ctrl_shadow[7]);
      return pt;
   endfunction

   // Every accepted request queues its predicted curve point.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_points.push_back(predict_point(req_bus.param_t));
      end
   end

   // Response side: random stalls per response and a field-by-field compare.
   always @(posedge clock) begin
      curve_point_type exp_pt;
      if (reset) begin
         recv_stall_left = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_points.size() == 0) begin
               $error("response with no request outstanding: x=%0d y=%0d",
                      rsp_bus.point_x, rsp_bus.point_y);
               mismatch_count++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_bus.point_x !== exp_pt.x) begin
                  $error("point_x: expected %0d, actual %0d", exp_pt.x, rsp_bus.point_x);
                  mismatch_count++;
               end
               if (rsp_bus.point_y !== exp_pt.y) begin
                  $error("point_y: expected %0d, actual %0d", exp_pt.y, rsp_bus.point_y);
                  mismatch_count++;
               end
            end
            recv_stall_left = recv_idle_on ? $urandom_range(0, 9) : 0;
         end else if (recv_stall_left > 0) begin
            recv_stall_left--;
         end
         rsp_bus.ready <= (recv_stall_left == 0);
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Send one request, after a random gap if send_idle_on is set, and wait until it is accepted.
   task automatic send_param(input bit [T_FRAC:0] param);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.param_t <= param;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold off new requests until every outstanding response has been checked.
   // It first lets the last accepted request reach the queue.
   task automatic drain_requests();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // Program all eight control coordinates, one register per cycle.
   task automatic load_curve(input bit [7:0][COORD-1:0] coords);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= coords[i];
         @(posedge clock);
         ctrl_shadow[i] = coords[i];
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic bit [T_FRAC:0] corner_param(input int k);
      case (k)
         0: return '0;
         1: return (T_FRAC+1)'(1);
         2: return T_ONE[T_FRAC:0] >> 1;
         3: return T_ONE[T_FRAC:0] - 1'b1;
         4: return T_ONE[T_FRAC:0];
         5: return T_ONE[T_FRAC:0] + 1'b1;
         6: return T_ONE[T_FRAC:0] + (T_ONE[T_FRAC:0] >> 1);
         default: return '1;
      endcase
   endfunction

   // Mostly in-range parameters, some corners and some above one (clamped).
   function automatic bit [T_FRAC:0] pick_param();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return (T_FRAC+1)'($urandom_range(0, 32'(T_ONE)));
      if (sel < 80) return corner_param(int'($urandom_range(0, 7)));
      return (T_FRAC+1)'($urandom_range(0, (1 << (T_FRAC + 1)) - 1));
   endfunction

   function automatic bit [7:0][COORD-1:0] pick_curve(input int style);
      bit [7:0][COORD-1:0] coords;
      for (int i = 0; i < 8; i++) begin
         case (style)
            1: coords[i] = '0;
            2: coords[i] = COORD_MAX;
            3: coords[i] = $urandom_range(0, 1) ? COORD_MAX : '0;
            default: coords[i] = COORD'($urandom_range(0, COORD_MAX));
         endcase
      end
      return coords;
   endfunction

   // Right after reset every control point sits at the origin.
   task automatic test_reset_state();
      send_param('0);
      send_param(T_ONE[T_FRAC:0]);
      drain_requests();
   endtask

   // Extreme curves swept over the parameter corners, including clamping.
   task automatic test_curve_extremes();
      bit [7:0][COORD-1:0] zigzag;
      for (int i = 0; i < 8; i++) zigzag[i] = (i % 3 == 0) ? COORD_MAX : '0;
      load_curve(zigzag);
      for (int k = 0; k < 8; k++) send_param(corner_param(k));
      drain_requests();
      load_curve(pick_curve(2));
      for (int k = 0; k < 8; k++) send_param(corner_param(k));
      drain_requests();
   endtask

   // Random curves and parameters across all idling combinations.
   task automatic test_random_curves();
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
         recv_idle_on = (phase % 4 == 0) || (phase % 4 == 1);
         load_curve(pick_curve((phase < 4) ? phase : 0));
         for (int n = 0; n < REQ_PER_PHASE; n++) begin
            send_param(pick_param());
            if (n == REQ_PER_PHASE / 2) drain_requests();
         end
         drain_requests();
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_CTRL0_X;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.param_t <= '0;
      ctrl_shadow = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      test_curve_extremes();
      test_random_curves();

      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_points.size() != 0) begin
         $error("%0d expected responses never arrived", expected_points.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
